### rtl/flash_array_model_defines.svh
// ---------------------------------------------------------------------------
// flash_array_model_defines.svh
// Assertion macros shared by the flash array model RTL.
// ---------------------------------------------------------------------------
`ifndef FLASH_ARRAY_MODEL_DEFINES_SVH
`define FLASH_ARRAY_MODEL_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define FAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define FAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fam_pkg.sv
// ---------------------------------------------------------------------------
// fam_pkg
// Shared sizes and codes of the flash array model.
// ---------------------------------------------------------------------------
package fam_pkg;

  localparam int ARRAY_BYTES = 65536;
  localparam int ADDR_W      = $clog2(ARRAY_BYTES);
  localparam int OFS_W       = 17;
  localparam int SUM_W       = OFS_W + 1;
  localparam int CNT_W       = $clog2(OFS_W + 1);

  localparam logic [7:0] ERASED_AT_RESET = 8'hFF;

  // command codes
  localparam logic [2:0] CMD_PROGRAM = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_ERASE   = 3'd2;
  localparam logic [2:0] CMD_VERIFY  = 3'd3;
  localparam logic [2:0] CMD_BLANK   = 3'd4;
  localparam logic [2:0] CMD_LOCK    = 3'd5;
  localparam logic [2:0] CMD_UNLOCK  = 3'd6;
  localparam logic [2:0] CMD_DATA    = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BADARGS     = 3'd1;
  localparam logic [2:0] ST_NOTBLANK    = 3'd2;
  localparam logic [2:0] ST_LOCKED      = 3'd3;
  localparam logic [2:0] ST_NOTVERIFIED = 3'd4;
  localparam logic [2:0] ST_NOOP        = 3'd5;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MEM_BYTES    = 2'd0;
  localparam logic [1:0] REG_SECTOR_BYTES = 2'd1;
  localparam logic [1:0] REG_PAGE_BYTES   = 2'd2;
  localparam logic [1:0] REG_ERASED_VALUE = 2'd3;

endpackage

### rtl/fam_ram.sv
// ---------------------------------------------------------------------------
// fam_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ---------------------------------------------------------------------------
module fam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

### rtl/fam_rem.sv
// ---------------------------------------------------------------------------
// fam_rem
// Restoring remainder unit: one dividend bit per cycle, over all OFS_W dividend bits.
// ---------------------------------------------------------------------------
module fam_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      go,
  input  logic [fam_pkg::OFS_W-1:0] dividend,
  input  logic [fam_pkg::OFS_W-1:0] divisor,
  output logic                      done,
  output logic [fam_pkg::OFS_W-1:0] rem
);

  localparam logic [fam_pkg::CNT_W-1:0] LAST_STEP = fam_pkg::CNT_W'(fam_pkg::OFS_W - 1);

  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [fam_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fam_pkg::OFS_W-1:0]   rem_r, rem_nxt;
  logic [fam_pkg::OFS_W-1:0]   dvd_r, dvd_nxt;
  logic [fam_pkg::OFS_W-1:0]   sor_r, sor_nxt;
  logic [fam_pkg::SUM_W-1:0]   trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    sor_nxt  = sor_r;
    trial    = {rem_r, dvd_r[fam_pkg::OFS_W-1]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = '0;
      dvd_nxt = dividend;
      sor_nxt = divisor;
    end else if (run_r) begin
      if (trial >= {1'b0, sor_r}) begin
        rem_nxt = fam_pkg::OFS_W'(trial - {1'b0, sor_r});
      end else begin
        rem_nxt = trial[fam_pkg::OFS_W-1:0];
      end
      dvd_nxt = {dvd_r[fam_pkg::OFS_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    sor_r <= sor_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

### rtl/flash_array_model.sv
// ---------------------------------------------------------------------------
// flash_array_model
// NOR-style flash array held in a 64 KiB byte RAM, driven by header and
// data commands, with an APB register port for geometry and erased value.
// ---------------------------------------------------------------------------
//
// Channel   Ports                       Transfer
// -------   -------------------------   -----------------------------------
// input     start/busy, in_*            rising edge with start=1, busy=0
// result    out_strobe, out_*           one cycle, strobe high, no backpressure
// config    psel/penable/pwrite/paddr   psel & penable & pwrite (pready=1)
//
// Lock, unlock, read/verify headers and program data are answered from idle.
//   Read and verify data: one RAM read, then compare/return.
//   Program header: a remainder check, then a blank walk over the bytes.
//   Erase header: two remainders, then an erase walk; blank check: a blank walk.
// Reset: a clearing pass writes 0xFF to all 65536 bytes with busy held high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`include "flash_array_model_defines.svh"

module flash_array_model (
  input  logic                      clk,
  input  logic                      rst_n,
  // input channel
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_cmd,
  input  logic [fam_pkg::OFS_W-1:0] in_start_offset,
  input  logic [fam_pkg::OFS_W-1:0] in_op_size,
  input  logic [7:0]                in_data_byte,
  // result channel
  output logic                      out_strobe,
  output logic [2:0]                out_status,
  output logic [7:0]                out_read_byte,
  output logic                      out_op_done,
  // config port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIVP, S_DIVE1, S_DIVE2, S_BLK_RD, S_BLK_CHK, S_ERS, S_DAT
  } state_t;

  typedef enum logic [1:0] {K_NONE, K_PROG, K_READ, K_VERIFY} kind_t;

  localparam logic [fam_pkg::SUM_W-1:0] ARRAY_LIM = fam_pkg::SUM_W'(fam_pkg::ARRAY_BYTES);

  // config registers
  logic [fam_pkg::OFS_W-1:0] cfg_mem_bytes_r, cfg_sector_bytes_r, cfg_page_bytes_r;
  logic [7:0]                cfg_erased_value_r;
  logic                      cfg_wr;

  // control state
  state_t                    state_r, state_nxt;
  kind_t                     kind_r, kind_nxt;
  logic                      lock_r, lock_nxt;
  logic                      mism_r, mism_nxt;
  logic                      is_prog_r, is_prog_nxt;
  logic [fam_pkg::OFS_W-1:0] next_addr_r, next_addr_nxt;
  logic [fam_pkg::OFS_W-1:0] left_r, left_nxt;
  logic [fam_pkg::OFS_W-1:0] op_start_r, op_start_nxt;
  logic [fam_pkg::OFS_W-1:0] op_size_r, op_size_nxt;
  logic [fam_pkg::OFS_W-1:0] walk_addr_r, walk_addr_nxt;
  logic [fam_pkg::OFS_W-1:0] walk_cnt_r, walk_cnt_nxt;
  logic [7:0]                data_r, data_nxt;
  logic                      div_go_r, div_go_nxt;
  logic [fam_pkg::OFS_W-1:0] div_dvd_r, div_dvd_nxt;
  logic [fam_pkg::OFS_W-1:0] div_sor_r, div_sor_nxt;
  logic                      out_strobe_r, out_strobe_nxt;
  logic [2:0]                out_status_r, out_status_nxt;
  logic [7:0]                out_read_byte_r, out_read_byte_nxt;
  logic                      out_op_done_r, out_op_done_nxt;

  // result for this cycle
  logic                      res_v;
  logic [2:0]                res_status;
  logic [7:0]                res_rd;
  logic                      res_done;

  // RAM port
  logic                      mem_we;
  logic [fam_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]                mem_wdata, mem_rdata;

  // remainder unit
  logic                      div_done;
  logic [fam_pkg::OFS_W-1:0] div_rem;

  logic [fam_pkg::SUM_W-1:0] usable, range_end;
  logic                      range_ok, data_noop, vmis;
  logic [7:0]                rd_byte;

  // assertion terms
  logic                      lock_xfer, res_pending;

  fam_ram #(.WIDTH(8), .DEPTH(fam_pkg::ARRAY_BYTES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  fam_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_dvd_r),
    .divisor  (div_sor_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign busy = (state_r != S_IDLE);

  // wide bound check: start + size <= min(mem_bytes, array size)
  assign usable    = ({1'b0, cfg_mem_bytes_r} < ARRAY_LIM) ? {1'b0, cfg_mem_bytes_r}
                                                           : ARRAY_LIM;
  assign range_end = {1'b0, in_start_offset} + {1'b0, in_op_size};
  assign range_ok  = (range_end <= usable);
  assign data_noop = (kind_r == K_NONE) || (left_r == '0) ||
                     ({1'b0, next_addr_r} >= ARRAY_LIM);
  assign rd_byte   = mem_rdata;
  assign vmis      = (kind_r == K_VERIFY) && (rd_byte != data_r);

  always_comb begin
    state_nxt         = state_r;
    kind_nxt          = kind_r;
    lock_nxt          = lock_r;
    mism_nxt          = mism_r;
    is_prog_nxt       = is_prog_r;
    next_addr_nxt     = next_addr_r;
    left_nxt          = left_r;
    op_start_nxt      = op_start_r;
    op_size_nxt       = op_size_r;
    walk_addr_nxt     = walk_addr_r;
    walk_cnt_nxt      = walk_cnt_r;
    data_nxt          = data_r;
    div_go_nxt        = 1'b0;
    div_dvd_nxt       = div_dvd_r;
    div_sor_nxt       = div_sor_r;
    res_v             = 1'b0;
    res_status        = fam_pkg::ST_OK;
    res_rd            = 8'h00;
    res_done          = 1'b1;
    mem_we            = 1'b0;
    mem_addr          = walk_addr_r[fam_pkg::ADDR_W-1:0];
    mem_wdata         = cfg_erased_value_r;

    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = fam_pkg::ERASED_AT_RESET;
        if (walk_addr_r[fam_pkg::ADDR_W-1:0] == '1) begin
          state_nxt = S_IDLE;
        end else begin
          walk_addr_nxt = walk_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (in_cmd != fam_pkg::CMD_DATA) begin
            kind_nxt = K_NONE;
            left_nxt = '0;
          end
          case (in_cmd)
            fam_pkg::CMD_LOCK: begin
              lock_nxt = 1'b1;
              res_v    = 1'b1;
            end
            fam_pkg::CMD_UNLOCK: begin
              lock_nxt = 1'b0;
              res_v    = 1'b1;
            end
            fam_pkg::CMD_READ, fam_pkg::CMD_VERIFY: begin
              res_v = 1'b1;
              if (!range_ok) begin
                res_status = fam_pkg::ST_BADARGS;
              end else if (in_op_size != '0) begin
                kind_nxt      = (in_cmd == fam_pkg::CMD_READ) ? K_READ : K_VERIFY;
                next_addr_nxt = in_start_offset;
                left_nxt      = in_op_size;
                mism_nxt      = 1'b0;
                res_done      = 1'b0;
              end
            end
            fam_pkg::CMD_PROGRAM: begin
              if (!range_ok || cfg_page_bytes_r == '0) begin
                res_v      = 1'b1;
                res_status = fam_pkg::ST_BADARGS;
              end else begin
                op_start_nxt = in_start_offset;
                op_size_nxt  = in_op_size;
                is_prog_nxt  = 1'b1;
                div_go_nxt   = 1'b1;
                div_dvd_nxt  = in_op_size;
                div_sor_nxt  = cfg_page_bytes_r;
                state_nxt    = S_DIVP;
              end
            end
            fam_pkg::CMD_ERASE: begin
              if (!range_ok || cfg_sector_bytes_r == '0) begin
                res_v      = 1'b1;
                res_status = fam_pkg::ST_BADARGS;
              end else begin
                op_start_nxt = in_start_offset;
                op_size_nxt  = in_op_size;
                div_go_nxt   = 1'b1;
                div_dvd_nxt  = in_start_offset;
                div_sor_nxt  = cfg_sector_bytes_r;
                state_nxt    = S_DIVE1;
              end
            end
            fam_pkg::CMD_BLANK: begin
              if (!range_ok) begin
                res_v      = 1'b1;
                res_status = fam_pkg::ST_BADARGS;
              end else begin
                op_size_nxt   = in_op_size;
                walk_addr_nxt = in_start_offset;
                walk_cnt_nxt  = in_op_size;
                is_prog_nxt   = 1'b0;
                state_nxt     = S_BLK_RD;
              end
            end
            default: begin
              // data item
              if (data_noop) begin
                kind_nxt   = K_NONE;
                res_v      = 1'b1;
                res_status = fam_pkg::ST_NOOP;
                res_done   = 1'b0;
              end else if (kind_r == K_PROG) begin
                mem_we        = 1'b1;
                mem_addr      = next_addr_r[fam_pkg::ADDR_W-1:0];
                mem_wdata     = in_data_byte;
                next_addr_nxt = next_addr_r + 1'b1;
                left_nxt      = left_r - 1'b1;
                res_v         = 1'b1;
                if (left_r == fam_pkg::OFS_W'(1)) begin
                  kind_nxt = K_NONE;
                  mism_nxt = 1'b0;
                end else begin
                  res_done = 1'b0;
                end
              end else begin
                mem_addr  = next_addr_r[fam_pkg::ADDR_W-1:0];
                data_nxt  = in_data_byte;
                state_nxt = S_DAT;
              end
            end
          endcase
        end
      end

      S_DAT: begin
        res_v         = 1'b1;
        res_rd        = (kind_r == K_READ) ? rd_byte : 8'h00;
        next_addr_nxt = next_addr_r + 1'b1;
        left_nxt      = left_r - 1'b1;
        if (left_r == fam_pkg::OFS_W'(1)) begin
          if (mism_r || vmis) begin
            res_status = fam_pkg::ST_NOTVERIFIED;
          end
          kind_nxt = K_NONE;
          mism_nxt = 1'b0;
        end else begin
          mism_nxt = mism_r || vmis;
          res_done = 1'b0;
        end
      end

      S_DIVP: begin
        if (div_done) begin
          if (div_rem != '0) begin
            res_v      = 1'b1;
            res_status = fam_pkg::ST_BADARGS;
          end else begin
            walk_addr_nxt = op_start_r;
            walk_cnt_nxt  = op_size_r;
            state_nxt     = S_BLK_RD;
          end
        end
      end

      S_BLK_RD: begin
        if (walk_cnt_r == '0) begin
          res_v = 1'b1;
          if (is_prog_r && op_size_r != '0) begin
            if (lock_r) begin
              res_status = fam_pkg::ST_LOCKED;
            end else begin
              kind_nxt      = K_PROG;
              next_addr_nxt = op_start_r;
              left_nxt      = op_size_r;
              mism_nxt      = 1'b0;
              res_done      = 1'b0;
            end
          end
        end else begin
          state_nxt = S_BLK_CHK;
        end
      end

      S_BLK_CHK: begin
        if (rd_byte != cfg_erased_value_r) begin
          res_v      = 1'b1;
          res_status = fam_pkg::ST_NOTBLANK;
        end else begin
          walk_addr_nxt = walk_addr_r + 1'b1;
          walk_cnt_nxt  = walk_cnt_r - 1'b1;
          state_nxt     = S_BLK_RD;
        end
      end

      S_DIVE1: begin
        if (div_done) begin
          if (div_rem != '0) begin
            res_v      = 1'b1;
            res_status = fam_pkg::ST_BADARGS;
          end else begin
            div_go_nxt  = 1'b1;
            div_dvd_nxt = op_size_r;
            state_nxt   = S_DIVE2;
          end
        end
      end

      S_DIVE2: begin
        if (div_done) begin
          if (div_rem != '0) begin
            res_v      = 1'b1;
            res_status = fam_pkg::ST_BADARGS;
          end else if (op_size_r != '0 && lock_r) begin
            res_v      = 1'b1;
            res_status = fam_pkg::ST_LOCKED;
          end else if (op_size_r != '0) begin
            walk_addr_nxt = op_start_r;
            walk_cnt_nxt  = op_size_r;
            state_nxt     = S_ERS;
          end else begin
            res_v = 1'b1;
          end
        end
      end

      S_ERS: begin
        if (walk_cnt_r == '0) begin
          res_v = 1'b1;
        end else begin
          mem_we        = 1'b1;
          walk_addr_nxt = walk_addr_r + 1'b1;
          walk_cnt_nxt  = walk_cnt_r - 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_strobe_nxt    = res_v;
    out_status_nxt    = res_status;
    out_read_byte_nxt = res_rd;
    out_op_done_nxt   = res_done;
    if (res_v) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      kind_r       <= K_NONE;
      lock_r       <= 1'b0;
      mism_r       <= 1'b0;
      next_addr_r  <= '0;
      left_r       <= '0;
      walk_addr_r  <= '0;
      div_go_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      kind_r       <= kind_nxt;
      lock_r       <= lock_nxt;
      mism_r       <= mism_nxt;
      next_addr_r  <= next_addr_nxt;
      left_r       <= left_nxt;
      walk_addr_r  <= walk_addr_nxt;
      div_go_r     <= div_go_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    is_prog_r       <= is_prog_nxt;
    op_start_r      <= op_start_nxt;
    op_size_r       <= op_size_nxt;
    walk_cnt_r      <= walk_cnt_nxt;
    data_r          <= data_nxt;
    div_dvd_r       <= div_dvd_nxt;
    div_sor_r       <= div_sor_nxt;
    out_status_r    <= out_status_nxt;
    out_read_byte_r <= out_read_byte_nxt;
    out_op_done_r   <= out_op_done_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_read_byte = out_read_byte_r;
  assign out_op_done   = out_op_done_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mem_bytes_r    <= fam_pkg::OFS_W'(65536);
      cfg_sector_bytes_r <= fam_pkg::OFS_W'(4096);
      cfg_page_bytes_r   <= fam_pkg::OFS_W'(256);
      cfg_erased_value_r <= 8'hFF;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        fam_pkg::REG_MEM_BYTES:    cfg_mem_bytes_r    <= pwdata[fam_pkg::OFS_W-1:0];
        fam_pkg::REG_SECTOR_BYTES: cfg_sector_bytes_r <= pwdata[fam_pkg::OFS_W-1:0];
        fam_pkg::REG_PAGE_BYTES:   cfg_page_bytes_r   <= pwdata[fam_pkg::OFS_W-1:0];
        fam_pkg::REG_ERASED_VALUE: cfg_erased_value_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fam_pkg::REG_MEM_BYTES:    prdata = 32'(cfg_mem_bytes_r);
      fam_pkg::REG_SECTOR_BYTES: prdata = 32'(cfg_sector_bytes_r);
      fam_pkg::REG_PAGE_BYTES:   prdata = 32'(cfg_page_bytes_r);
      fam_pkg::REG_ERASED_VALUE: prdata = 32'(cfg_erased_value_r);
      default:                   prdata = '0;
    endcase
  end

  // checks
  assign lock_xfer   = start && !busy &&
                       (in_cmd == fam_pkg::CMD_LOCK || in_cmd == fam_pkg::CMD_UNLOCK);
  assign res_pending = out_strobe_r && !out_op_done_r && out_status_r != fam_pkg::ST_NOOP;

  `FAM_ASSERT_NOW(a_result_frees, out_strobe_r, state_r == S_IDLE, "result while busy")
  `FAM_ASSERT_NEXT(a_lock_answers, lock_xfer, out_strobe_r && out_op_done_r, "lock lost")
  `FAM_ASSERT_NOW(a_open_tracks, res_pending, kind_r != K_NONE, "pending op not open")

endmodule
